>>> rtl/dense_matrix_vector_bias_core_defines.svh
// ----------------------------------------------------------------------------
// Dense matrix-vector bias core: assertion macros
// Clocked, reset-qualified property checks used by the core RTL. They expand
// to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DENSE_MATRIX_VECTOR_BIAS_CORE_DEFINES_SVH
`define DENSE_MATRIX_VECTOR_BIAS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property checked at every clock edge out of reset
`define DMVB_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// consequent must hold in the cycle after the antecedent
`define DMVB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DMVB_ASSERT(name, prop, msg)
`define DMVB_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

>>> rtl/dmvb_pkg.sv
// ----------------------------------------------------------------------------
// Dense matrix-vector bias core: shared package
// Widths, register indexes, state codes and the MAC control bundle.
// ----------------------------------------------------------------------------
package dmvb_pkg;

    // vector store geometry
    localparam int VEC_DEPTH   = 256;
    localparam int VEC_AW      = $clog2(VEC_DEPTH);
    localparam int MAX_COLUMNS = VEC_DEPTH;
    localparam int MAX_ROWS    = 256;
    localparam int ROW_AW      = $clog2(MAX_ROWS);

    // field widths
    localparam int COUNT_W   = 9;
    localparam int VALUE_W   = 16;
    localparam int BIAS_W    = 32;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int ACC_W     = 48;
    localparam int RESULT_W  = 32;
    localparam int ROW_IDX_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = COUNT_W;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    // clamped counts as count-width constants
    localparam logic [COUNT_W-1:0] MAX_ROWS_C    = COUNT_W'(MAX_ROWS);
    localparam logic [COUNT_W-1:0] MAX_COLUMNS_C = COUNT_W'(MAX_COLUMNS);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT    = 2'd0,
        REG_COLUMN_COUNT = 2'd1,
        REG_BIAS_ENABLE  = 2'd2
    } cfg_reg_t;

    // input selector and output status codes
    localparam logic FUNC_LOAD      = 1'b0;
    localparam logic FUNC_WEIGHT    = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ACC  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    // control from the sequencer to the MAC
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
        logic bias_en;
        logic clear;
    } mac_ctrl_t;

endpackage

>>> rtl/dense_matrix_vector_bias_core.sv
// ----------------------------------------------------------------------------
// Dense matrix-vector bias core: top level
// Load word: taken in S_IDLE, writes the vector RAM. Weight word: accept and
// registered RAM read, multiply (S_MUL), accumulate (S_ACC); a row's last weight
// then waits in S_OUT for the output register. Invalid-config weight: straight
// to S_OUT for a status word. Input ready only in S_IDLE; one MAC for all rows.
// Reset clears counters and state; counts reset to 1, bias off; RAM not cleared.
// ----------------------------------------------------------------------------
`include "dense_matrix_vector_bias_core_defines.svh"

module dense_matrix_vector_bias_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [dmvb_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [dmvb_pkg::CFG_W-1:0]           cfg_wdata,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [dmvb_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // value[15:0], bias_value[47:16]
    input  logic                                 s_axis_tuser,  // func[0]
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [dmvb_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // result_value[31:0], row_index[39:32]
    output logic                                 m_axis_tlast,  // last_row
    output logic                                 m_axis_tuser   // status[0]
);

    localparam int COUNT_W = dmvb_pkg::COUNT_W;
    localparam int VEC_AW  = dmvb_pkg::VEC_AW;
    localparam int ROW_AW  = dmvb_pkg::ROW_AW;
    localparam int VALUE_W = dmvb_pkg::VALUE_W;
    localparam int BIAS_W  = dmvb_pkg::BIAS_W;

    // configuration registers
    logic [COUNT_W-1:0] row_count_reg;
    logic [COUNT_W-1:0] column_count_reg;
    logic               bias_enable_reg;
    logic               count_write;

    // positions and sequencer
    dmvb_pkg::state_t   state_reg, state_next;
    logic [VEC_AW-1:0]  load_ptr_reg, load_ptr_next;
    logic [VEC_AW-1:0]  col_pos_reg, col_pos_next;
    logic [ROW_AW-1:0]  row_pos_reg, row_pos_next;

    // per-item payload held while it is worked on
    logic signed [VALUE_W-1:0] weight_reg;
    logic signed [BIAS_W-1:0]  bias_reg;
    logic                      first_reg;
    logic                      last_col_reg;
    logic                      last_row_reg;
    logic                      invalid_reg;
    logic [ROW_AW-1:0]         row_idx_reg;

    // output register
    logic                                  m_valid_reg;
    logic [dmvb_pkg::OUT_DATA_W-1:0]       m_data_reg;
    logic                                  m_last_reg;
    logic                                  m_user_reg;

    logic [COUNT_W-1:0]        rows_eff;
    logic [COUNT_W-1:0]        cols_eff;
    logic                      cfg_valid;
    logic                      in_accept;
    logic                      in_weight;
    logic                      load_fire;
    logic                      weight_fire;
    logic                      cur_last_col;
    logic                      cur_last_row;
    logic                      out_load;
    logic [VALUE_W-1:0]        in_value;
    logic [BIAS_W-1:0]         in_bias;
    logic [VALUE_W-1:0]        ram_rd_data;
    logic signed [dmvb_pkg::RESULT_W-1:0] sat_sum;
    dmvb_pkg::mac_ctrl_t       mac_ctrl;

    // input unpacking and handshake
    assign in_value      = s_axis_tdata[VALUE_W-1:0];
    assign in_bias       = s_axis_tdata[VALUE_W+BIAS_W-1:VALUE_W];
    assign in_weight     = (s_axis_tuser == dmvb_pkg::FUNC_WEIGHT);
    assign s_axis_tready = (state_reg == dmvb_pkg::S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // effective counts, clamped to the storage size
    assign rows_eff  = (row_count_reg > dmvb_pkg::MAX_ROWS_C) ?
                       dmvb_pkg::MAX_ROWS_C : row_count_reg;
    assign cols_eff  = (column_count_reg > dmvb_pkg::MAX_COLUMNS_C) ?
                       dmvb_pkg::MAX_COLUMNS_C : column_count_reg;
    assign cfg_valid = (rows_eff != '0) && (cols_eff != '0);

    assign load_fire    = in_accept && !in_weight && cfg_valid;
    assign weight_fire  = in_accept && in_weight && cfg_valid;
    assign cur_last_col = (COUNT_W'(col_pos_reg) + COUNT_W'(1)) >= cols_eff;
    assign cur_last_row = (COUNT_W'(row_pos_reg) + COUNT_W'(1)) >= rows_eff;

    // configuration writes
    assign count_write = cfg_wr_en &&
                         ((cfg_addr == dmvb_pkg::REG_ROW_COUNT) ||
                          (cfg_addr == dmvb_pkg::REG_COLUMN_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= COUNT_W'(1);
            column_count_reg <= COUNT_W'(1);
            bias_enable_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (dmvb_pkg::cfg_reg_t'(cfg_addr))
                dmvb_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_wdata;
                dmvb_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_wdata;
                dmvb_pkg::REG_BIAS_ENABLE:  bias_enable_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // output slot is free or being drained this cycle
    assign out_load = (state_reg == dmvb_pkg::S_OUT) && (!m_valid_reg || m_axis_tready);

    // sequencer and position counters
    always_comb
    begin
        state_next    = state_reg;
        load_ptr_next = load_ptr_reg;
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;

        case (state_reg)
            dmvb_pkg::S_IDLE:
            begin
                if (load_fire)
                begin
                    load_ptr_next = ((COUNT_W'(load_ptr_reg) + COUNT_W'(1)) >= cols_eff) ?
                                    '0 : load_ptr_reg + VEC_AW'(1);
                end
                if (weight_fire)
                begin
                    state_next = dmvb_pkg::S_MUL;
                    if (cur_last_col)
                    begin
                        col_pos_next = '0;
                        row_pos_next = cur_last_row ? '0 : row_pos_reg + ROW_AW'(1);
                    end
                    else
                    begin
                        col_pos_next = col_pos_reg + VEC_AW'(1);
                    end
                end
                else if (in_accept && in_weight)
                begin
                    // weight under invalid counts: status word only
                    state_next = dmvb_pkg::S_OUT;
                end
            end
            dmvb_pkg::S_MUL:
            begin
                state_next = dmvb_pkg::S_ACC;
            end
            dmvb_pkg::S_ACC:
            begin
                state_next = last_col_reg ? dmvb_pkg::S_OUT : dmvb_pkg::S_IDLE;
            end
            dmvb_pkg::S_OUT:
            begin
                if (out_load)
                begin
                    state_next = dmvb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dmvb_pkg::S_IDLE;
            end
        endcase

        if (count_write)
        begin
            load_ptr_next = '0;
            col_pos_next  = '0;
            row_pos_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dmvb_pkg::S_IDLE;
            load_ptr_reg <= '0;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_ptr_reg <= load_ptr_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
        end
    end

    // capture the accepted weight and its row bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invalid_reg <= 1'b0;
        end
        else if (in_accept && in_weight)
        begin
            invalid_reg <= !cfg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (weight_fire)
        begin
            weight_reg   <= in_value;
            bias_reg     <= in_bias;
            first_reg    <= (col_pos_reg == '0);
            last_col_reg <= cur_last_col;
            last_row_reg <= cur_last_row;
            row_idx_reg  <= row_pos_reg;
        end
    end

    // vector store
    dmvb_vector_ram u_vector_ram (
        .clk     (clk),
        .wr_en   (load_fire),
        .wr_addr (load_ptr_reg),
        .wr_data (in_value),
        .rd_en   (weight_fire),
        .rd_addr (col_pos_reg),
        .rd_data (ram_rd_data)
    );

    // multiply-accumulate
    assign mac_ctrl.mul_en  = (state_reg == dmvb_pkg::S_MUL);
    assign mac_ctrl.acc_en  = (state_reg == dmvb_pkg::S_ACC);
    assign mac_ctrl.first   = first_reg;
    assign mac_ctrl.bias_en = bias_enable_reg;
    assign mac_ctrl.clear   = count_write;

    dmvb_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .weight  (weight_reg),
        .element (ram_rd_data),
        .bias    (bias_reg),
        .sat_sum (sat_sum)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (invalid_reg)
            begin
                m_data_reg <= '0;
                m_last_reg <= 1'b0;
                m_user_reg <= dmvb_pkg::STATUS_INVALID;
            end
            else
            begin
                m_data_reg <= {dmvb_pkg::ROW_IDX_W'(row_idx_reg), sat_sum};
                m_last_reg <= last_row_reg;
                m_user_reg <= dmvb_pkg::STATUS_OK;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    // checks
    `DMVB_ASSERT(a_col_in_range, cfg_valid |-> (COUNT_W'(col_pos_reg) < cols_eff), "column position out of range")
    `DMVB_ASSERT_NEXT(a_weight_to_mul, weight_fire && !count_write, state_reg == dmvb_pkg::S_MUL, "weight did not start multiply")
    `DMVB_ASSERT_NEXT(a_out_holds, (state_reg == dmvb_pkg::S_OUT) && m_valid_reg && !m_axis_tready, state_reg == dmvb_pkg::S_OUT, "result dropped while output full")
    `DMVB_ASSERT(a_invalid_zero, (m_valid_reg && (m_user_reg == dmvb_pkg::STATUS_INVALID)) |-> ((m_data_reg == '0) && !m_last_reg), "invalid status carries data")

endmodule

>>> rtl/dmvb_vector_ram.sv
// ----------------------------------------------------------------------------
// Dense matrix-vector bias core: vector store
// Single-port-write, single-port-read synchronous RAM holding the input
// vector. Read data is registered.
// ----------------------------------------------------------------------------
module dmvb_vector_ram (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [dmvb_pkg::VEC_AW-1:0]   wr_addr,
    input  logic [dmvb_pkg::VALUE_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [dmvb_pkg::VEC_AW-1:0]   rd_addr,
    output logic [dmvb_pkg::VALUE_W-1:0]  rd_data
);

    logic [dmvb_pkg::VALUE_W-1:0] mem [dmvb_pkg::VEC_DEPTH];
    logic [dmvb_pkg::VALUE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/dmvb_mac.sv
// ----------------------------------------------------------------------------
// Dense matrix-vector bias core: multiply-accumulate unit
// Registered 16x16 product, 48-bit accumulator seeded with bias or zero on a
// row's first column, and saturation of the sum to signed 32 bits.
// ----------------------------------------------------------------------------
module dmvb_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dmvb_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [dmvb_pkg::VALUE_W-1:0]   weight,
    input  logic signed [dmvb_pkg::VALUE_W-1:0]   element,
    input  logic signed [dmvb_pkg::BIAS_W-1:0]    bias,
    output logic signed [dmvb_pkg::RESULT_W-1:0]  sat_sum
);

    localparam int ACC_W    = dmvb_pkg::ACC_W;
    localparam int RESULT_W = dmvb_pkg::RESULT_W;

    logic signed [dmvb_pkg::PROD_W-1:0] product_reg;
    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [ACC_W-1:0]            acc_next;
    logic signed [ACC_W-1:0]            acc_base;
    logic                               fits;

    // product stage
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            product_reg <= weight * element;
        end
    end

    // accumulate: first column restarts from bias or zero
    always_comb
    begin
        if (ctrl.first)
        begin
            acc_base = ctrl.bias_en ? ACC_W'(bias) : '0;
        end
        else
        begin
            acc_base = acc_reg;
        end
        acc_next = acc_base + ACC_W'(product_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // saturate: fits when all bits above the result sign match it
    assign fits = (acc_reg[ACC_W-1:RESULT_W-1] == '0) || (acc_reg[ACC_W-1:RESULT_W-1] == '1);

    always_comb
    begin
        if (fits)
        begin
            sat_sum = acc_reg[RESULT_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            sat_sum = {1'b1, {(RESULT_W-1){1'b0}}};
        end
        else
        begin
            sat_sum = {1'b0, {(RESULT_W-1){1'b1}}};
        end
    end

endmodule

>>> dv/dense_matrix_vector_bias_core_tb.sv
// ----------------------------------------------------------------------------
// Dense matrix-vector bias core: testbench
// Drives vector-load and weight words into the core and predicts every row
// result: Q4.12 products summed over a row on top of an optional Q8.24 bias,
// saturated to 32 bits. The tests cover reset defaults, invalid counts,
// saturation, load and row wrap, count writes, full-size rows and columns,
// and random layers. Both stream sides idle at random, and the result side
// also holds off for long stretches.
// ----------------------------------------------------------------------------
module dense_matrix_vector_bias_core_tb;

    localparam int RESULT_W    = dmvb_pkg::RESULT_W;
    localparam int ROW_IDX_W   = dmvb_pkg::ROW_IDX_W;
    localparam int CFG_W       = dmvb_pkg::CFG_W;
    localparam int IN_DATA_W   = dmvb_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = dmvb_pkg::OUT_DATA_W;
    localparam int VALUE_W     = dmvb_pkg::VALUE_W;
    localparam int BIAS_W      = dmvb_pkg::BIAS_W;
    localparam int COUNT_W     = dmvb_pkg::COUNT_W;
    localparam int VEC_AW      = dmvb_pkg::VEC_AW;
    localparam int VEC_DEPTH   = dmvb_pkg::VEC_DEPTH;
    localparam int MAX_ROWS    = dmvb_pkg::MAX_ROWS;
    localparam int MAX_COLUMNS = dmvb_pkg::MAX_COLUMNS;

    // one row result as it leaves the core
    typedef struct packed {
        logic [RESULT_W-1:0]  sum;
        logic [ROW_IDX_W-1:0] row;
        logic                 last_row;
        logic                 status;
    } row_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    dmvb_pkg::cfg_reg_t    cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // value[15:0], bias_value[47:16]
    logic                  s_axis_tuser;   // func[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // result_value[31:0], row_index[39:32]
    logic                  m_axis_tlast;   // last_row
    logic                  m_axis_tuser;   // status[0]

    // predictor state and configuration
    logic [VALUE_W-1:0] vec_mem [0:VEC_DEPTH-1];
    int                 load_ptr;
    int                 col_pos;
    int                 row_pos;
    longint             acc;
    logic [COUNT_W-1:0] rows_cfg;
    logic [COUNT_W-1:0] cols_cfg;
    logic               bias_on;

    row_result_t row_results_q[$];
    int          error_count = 0;

    // idling knobs shared by the stimulus and the result sink
    int tx_gap_max    = 8;
    int rx_stall_max  = 8;
    int rx_hold_cycles = 0;

    dense_matrix_vector_bias_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // clears the positions, as a count write does
    function automatic void clear_positions();
        load_ptr = 0;
        col_pos  = 0;
        row_pos  = 0;
        acc      = 0;
    endfunction

    // advances the layer state by one accepted word
    function automatic void dense_layer_step(input logic fn, input logic [VALUE_W-1:0] val,
                                             input logic [BIAS_W-1:0] bias);
        int          rows;
        int          cols;
        longint      sat;
        row_result_t r;
        rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
        cols = (cols_cfg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_cfg);

        // zero counts: weights report invalid, loads are dropped
        if (rows == 0 || cols == 0)
        begin
            if (fn == dmvb_pkg::FUNC_WEIGHT)
            begin
                r = '{sum: '0, row: '0, last_row: 1'b0, status: dmvb_pkg::STATUS_INVALID};
                row_results_q.push_back(r);
            end
            return;
        end

        if (fn == dmvb_pkg::FUNC_LOAD)
        begin
            if (load_ptr >= cols)
                load_ptr = 0;
            vec_mem[load_ptr[VEC_AW-1:0]] = val;
            load_ptr = (load_ptr + 1 >= cols) ? 0 : load_ptr + 1;
            return;
        end

        if (col_pos >= cols)
            col_pos = 0;
        if (row_pos >= rows)
            row_pos = 0;
        if (col_pos == 0)
            acc = bias_on ? longint'($signed(bias)) : 64'sd0;
        acc += longint'($signed(val)) * longint'($signed(vec_mem[col_pos[VEC_AW-1:0]]));

        if (col_pos + 1 < cols)
        begin
            col_pos++;
            return;
        end

        // row done: saturate and emit
        sat = acc;
        if (sat > 64'sd2147483647)
            sat = 64'sd2147483647;
        if (sat < -64'sd2147483648)
            sat = -64'sd2147483648;
        r.sum      = sat[RESULT_W-1:0];
        r.row      = row_pos[ROW_IDX_W-1:0];
        r.last_row = (row_pos + 1 >= rows);
        r.status   = dmvb_pkg::STATUS_OK;
        row_results_q.push_back(r);
        col_pos = 0;
        row_pos = r.last_row ? 0 : row_pos + 1;
        acc     = 0;
    endfunction

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                @(negedge clk) m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            gap = $urandom_range(0, rx_stall_max);
            if (gap > 0)
            begin
                @(negedge clk) m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk) m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        row_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (row_results_q.size() == 0)
            begin
                $error("unexpected result word: data %h last %b status %b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = row_results_q.pop_front();
                if (m_axis_tdata[31:0] !== want.sum)
                begin
                    $error("result_value mismatch: expected %h, got %h",
                           want.sum, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[39:32] !== want.row)
                begin
                    $error("row_index mismatch: expected %0d, got %0d",
                           want.row, m_axis_tdata[39:32]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last_row)
                begin
                    $error("last_row mismatch: expected %b, got %b",
                           want.last_row, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $error("status mismatch: expected %b, got %b",
                           want.status, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // sends one word after a random gap and feeds it to the predictor
    task automatic send_word(input logic fn, input logic [VALUE_W-1:0] val,
                             input logic [BIAS_W-1:0] bias);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            @(negedge clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bias, val};
        s_axis_tuser  <= fn;
        do @(posedge clk); while (!s_axis_tready);
        dense_layer_step(fn, val, bias);
    endtask

    // stops sending, waits for every pending result, then lets the core settle
    task automatic wait_drained();
        @(negedge clk) s_axis_tvalid <= 1'b0;
        while (row_results_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // register write, only with the core idle
    task automatic write_reg(input dmvb_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] data);
        wait_drained();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            dmvb_pkg::REG_ROW_COUNT:
            begin
                rows_cfg = data;
                clear_positions();
            end
            dmvb_pkg::REG_COLUMN_COUNT:
            begin
                cols_cfg = data;
                clear_positions();
            end
            dmvb_pkg::REG_BIAS_ENABLE:
                bias_on = data[0];
            default:
                ;
        endcase
        @(negedge clk) cfg_wr_en <= 1'b0;
    endtask

    // random operand with the extremes weighted in
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    function automatic logic [BIAS_W-1:0] pick_bias();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset counts are 1x1 with bias off
    task automatic test_reset_defaults();
        send_word(dmvb_pkg::FUNC_LOAD, 16'h7fff, 32'h0);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h7fff, 32'h12345678);
        send_word(dmvb_pkg::FUNC_LOAD, 16'h8000, 32'hffffffff);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h8000, 32'hffffffff);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h0000, 32'h0);
    endtask

    // zero rows or columns: weights flag invalid, loads are dropped
    task automatic test_invalid_counts();
        write_reg(dmvb_pkg::REG_ROW_COUNT, 9'd0);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h1234, 32'h0);
        send_word(dmvb_pkg::FUNC_LOAD, 16'h1111, 32'h0);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'hffff, 32'hffffffff);
        write_reg(dmvb_pkg::REG_ROW_COUNT, 9'd1);
        write_reg(dmvb_pkg::REG_COLUMN_COUNT, 9'd0);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h8000, 32'h0);
        send_word(dmvb_pkg::FUNC_LOAD, 16'h2222, 32'h0);
        // back to 1x1: the element stored before the invalid phase is still used
        write_reg(dmvb_pkg::REG_COLUMN_COUNT, 9'd1);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h0001, 32'h0);
    endtask

    // bias pushes the sum past both 32-bit limits
    task automatic test_saturation();
        write_reg(dmvb_pkg::REG_COLUMN_COUNT, 9'd2);
        write_reg(dmvb_pkg::REG_ROW_COUNT, 9'd2);
        write_reg(dmvb_pkg::REG_BIAS_ENABLE, 9'h1ff);
        send_word(dmvb_pkg::FUNC_LOAD, 16'h7fff, 32'h0);
        send_word(dmvb_pkg::FUNC_LOAD, 16'h7fff, 32'h0);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h7fff, 32'h7fffffff);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h7fff, 32'h80000000);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h8000, 32'h80000000);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h8000, 32'h7fffffff);
        write_reg(dmvb_pkg::REG_BIAS_ENABLE, 9'h0);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h8000, 32'h7fffffff);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h8000, 32'h7fffffff);
    endtask

    // load and row wrap, and a count write in the middle of a row
    task automatic test_wraps();
        write_reg(dmvb_pkg::REG_COLUMN_COUNT, 9'd3);
        write_reg(dmvb_pkg::REG_ROW_COUNT, 9'd2);
        repeat (5) send_word(dmvb_pkg::FUNC_LOAD, pick_value(), pick_bias());
        repeat (15) send_word(dmvb_pkg::FUNC_WEIGHT, pick_value(), pick_bias());
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h7fff, 32'h0);
        send_word(dmvb_pkg::FUNC_WEIGHT, 16'h7fff, 32'h0);
        // rewrite drops the partial row and the load position
        write_reg(dmvb_pkg::REG_COLUMN_COUNT, 9'd3);
        repeat (3) send_word(dmvb_pkg::FUNC_LOAD, pick_value(), pick_bias());
        repeat (3) send_word(dmvb_pkg::FUNC_WEIGHT, pick_value(), pick_bias());
        send_word(dmvb_pkg::FUNC_WEIGHT, pick_value(), pick_bias());
        write_reg(dmvb_pkg::REG_ROW_COUNT, 9'd2);
        repeat (6) send_word(dmvb_pkg::FUNC_WEIGHT, pick_value(), pick_bias());
    endtask

    // 256 single-column rows while the sink holds off, so the input stalls
    task automatic test_full_rows();
        write_reg(dmvb_pkg::REG_ROW_COUNT, 9'd256);
        write_reg(dmvb_pkg::REG_COLUMN_COUNT, 9'd1);
        write_reg(dmvb_pkg::REG_BIAS_ENABLE, 9'h1);
        send_word(dmvb_pkg::FUNC_LOAD, pick_value(), pick_bias());
        rx_hold_cycles = 200;
        repeat (256) send_word(dmvb_pkg::FUNC_WEIGHT, pick_value(), pick_bias());
    endtask

    // oversized counts act as the maximum: one full 256-column row
    task automatic test_full_columns();
        write_reg(dmvb_pkg::REG_COLUMN_COUNT, 9'd511);
        write_reg(dmvb_pkg::REG_ROW_COUNT, 9'd300);
        tx_gap_max = 0;
        repeat (256) send_word(dmvb_pkg::FUNC_LOAD, pick_value(), pick_bias());
        repeat (256) send_word(dmvb_pkg::FUNC_WEIGHT, pick_value(), pick_bias());
        tx_gap_max = 8;
    endtask

    // random small layers: full vector load, whole rows, some stray words
    task automatic test_random_layers();
        int sent;
        int rows;
        int cols;
        int reps;
        sent = 0;
        while (sent < 60)
        begin
            tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 8;
            rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            rows = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
            cols = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
            write_reg(dmvb_pkg::REG_ROW_COUNT, COUNT_W'(rows));
            write_reg(dmvb_pkg::REG_COLUMN_COUNT, COUNT_W'(cols));
            write_reg(dmvb_pkg::REG_BIAS_ENABLE,
                      {8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
            if (rows == 0 || cols == 0)
            begin
                repeat (4)
                begin
                    send_word(1'($urandom_range(0, 1)), pick_value(), pick_bias());
                    sent++;
                end
            end
            else
            begin
                repeat (cols)
                begin
                    send_word(dmvb_pkg::FUNC_LOAD, pick_value(), pick_bias());
                    sent++;
                end
                reps = $urandom_range(1, 2) * rows * cols;
                repeat (reps)
                begin
                    // stray word: a reload or an extra weight that shifts alignment
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_word(1'($urandom_range(0, 1)), pick_value(), pick_bias());
                        sent++;
                    end
                    send_word(dmvb_pkg::FUNC_WEIGHT, pick_value(), pick_bias());
                    sent++;
                    if ($urandom_range(0, 39) == 0)
                        wait_drained();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = dmvb_pkg::REG_ROW_COUNT;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = dmvb_pkg::FUNC_LOAD;
        rows_cfg      = 9'd1;
        cols_cfg      = 9'd1;
        bias_on       = 1'b0;
        clear_positions();
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_reset_defaults();
        test_invalid_counts();
        test_saturation();
        test_wraps();
        test_full_rows();
        test_full_columns();
        test_random_layers();
        wait_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/dmvb_pkg.sv
rtl/dmvb_vector_ram.sv
rtl/dmvb_mac.sv
rtl/dense_matrix_vector_bias_core.sv
dv/dense_matrix_vector_bias_core_tb.sv
